@@ sv/hrbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic restraint bond force package
// Item types, register codes and pipeline payload types of the bond force unit.
// ----------------------------------------------------------------------------
package hrbf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X     = 3'd0,
    CFG_BOX_Y     = 3'd1,
    CFG_BOX_Z     = 3'd2,
    CFG_PERIODIC  = 3'd3,
    CFG_ENERGY_EN = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACT_FORCE = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [3:0]         bond_type;
    logic [31:0]        stiffness_value;
    logic signed [31:0] cur_dx;
    logic signed [31:0] cur_dy;
    logic signed [31:0] cur_dz;
    logic signed [31:0] init_dx;
    logic signed [31:0] init_dy;
    logic signed [31:0] init_dz;
  } hrbf_in_t;

  typedef struct packed {
    logic signed [31:0] force_scale;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [62:0]        bond_energy;
    logic               zero_length;
  } hrbf_out_t;

  typedef struct packed {
    logic [31:0] k;
    logic [31:0] cmx;
    logic [31:0] cmy;
    logic [31:0] cmz;
    logic        csx;
    logic        csy;
    logic        csz;
  } pl_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } rt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
    logic [31:0] r;
    logic        neg;
    logic        nz;
    logic        zero;
    logic [63:0] d2;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [62:0] energy;
    pl_t         pl;
  } dv_t;

endpackage

@@ sv/harmonic_restraint_bond_force_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Harmonic restraint bond force unit
// Folds the initial bond vector, takes both bond lengths, and returns the
// force scale, the force on the first atom and the bond energy in Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction   Handshake               Payload
//  in        input       in_valid_i / in_stall_o  hrbf_in_t
//  out       output      out_valid_o / out_stall_i hrbf_out_t
//  cfg       input       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item enters per cycle unless a stalled output holds the input; force items leave in order.
// The pipeline holds the 32-stage square root and 32-stage divider pipelines.
// A stiffness write gives no output item.
// After reset the stiffness table reads zero through per-entry valid bits.
// A stalled output freezes the whole pipeline, bubbles included.

module harmonic_restraint_bond_force_unit
  import hrbf_pkg::*;
#(
  parameter int BOND_TYPES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hrbf_in_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hrbf_out_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int IDX_W = (BOND_TYPES > 1) ? $clog2(BOND_TYPES) : 1;
  localparam int NSTG  = 10 + SQRT_STEPS + DIV_STEPS;

  function automatic logic signed [31:0] fold(input logic signed [31:0] d,
                                              input logic [31:0] box,
                                              input logic per);
    logic signed [33:0] t;
    logic [32:0]        m;
    t = 34'(d);
    m = t[33] ? 33'(-t) : 33'(t);
    if (per && (({1'b0, m} << 1) > {2'b00, box})) begin
      t = t[33] ? (t + $signed({2'b00, box})) : (t - $signed({2'b00, box}));
    end
    if (t > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(t);
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] d);
    logic [31:0] u;
    u = d;
    return d[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic rt_t sqrt_step(input rt_t a, input logic [63:0] b);
    rt_t         o;
    logic [63:0] t;
    t = a.res + b;
    if (a.x >= t) begin
      o.x   = a.x - t;
      o.res = (a.res >> 1) + b;
    end else begin
      o.x   = a.x;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat_force(input logic [63:0] p, input logic neg);
    logic [47:0] m;
    logic [31:0] mm;
    m = p[63:16];
    if (neg) begin
      mm = (m > 48'h0000_8000_0000) ? 32'h8000_0000 : m[31:0];
      return ~mm + 32'd1;
    end
    return (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  logic adv, in_acc;
  logic [NSTG-1:0] v_q;

  assign in_stall_o  = out_valid_o && out_stall_i;
  assign adv         = !in_stall_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_acc && (in_item_i.action == ACT_FORCE)};
    end
  end

  // Configuration registers.
  logic [31:0] box_x_q, box_y_q, box_z_q;
  logic [2:0]  per_q;
  logic        een_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= '0;
      box_y_q <= '0;
      box_z_q <= '0;
      per_q   <= 3'd7;
      een_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BOX_X:     box_x_q <= cfg_data_i;
        CFG_BOX_Y:     box_y_q <= cfg_data_i;
        CFG_BOX_Z:     box_z_q <= cfg_data_i;
        CFG_PERIODIC:  per_q   <= cfg_data_i[2:0];
        CFG_ENERGY_EN: een_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stiffness table.
  logic [31:0]           tbl [BOND_TYPES];
  logic [BOND_TYPES-1:0] tbl_vld_q;
  logic [8:0]            type_ext;
  logic [IDX_W-1:0]      tbl_idx;
  logic                  in_rng, tbl_we;

  assign type_ext = 9'(in_item_i.bond_type);
  assign tbl_idx  = type_ext[IDX_W-1:0];
  assign in_rng   = ({28'd0, in_item_i.bond_type} < BOND_TYPES);
  assign tbl_we   = in_acc && (in_item_i.action == ACT_WRITE) && in_rng;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl[tbl_idx] <= in_item_i.stiffness_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
    end else if (tbl_we) begin
      tbl_vld_q[tbl_idx] <= 1'b1;
    end
  end

  // Input stage with table read.
  hrbf_in_t    in_q;
  logic [31:0] tk_q;
  logic        tkv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q  <= in_item_i;
      tk_q  <= tbl[tbl_idx];
      tkv_q <= in_rng && tbl_vld_q[tbl_idx];
    end
  end

  // Fold stage.
  logic [31:0]        f_k_q;
  logic signed [31:0] f_c_q [3];
  logic signed [31:0] f_i_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_k_q    <= tkv_q ? tk_q : 32'd0;
      f_c_q[0] <= in_q.cur_dx;
      f_c_q[1] <= in_q.cur_dy;
      f_c_q[2] <= in_q.cur_dz;
      f_i_q[0] <= fold(in_q.init_dx, box_x_q, per_q[0]);
      f_i_q[1] <= fold(in_q.init_dy, box_y_q, per_q[1]);
      f_i_q[2] <= fold(in_q.init_dz, box_z_q, per_q[2]);
    end
  end

  // Magnitude stage.
  pl_t         m_pl_q;
  logic [31:0] m_im_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_pl_q.k   <= f_k_q;
      m_pl_q.cmx <= mag(f_c_q[0]);
      m_pl_q.cmy <= mag(f_c_q[1]);
      m_pl_q.cmz <= mag(f_c_q[2]);
      m_pl_q.csx <= f_c_q[0][31];
      m_pl_q.csy <= f_c_q[1][31];
      m_pl_q.csz <= f_c_q[2][31];
      for (int i = 0; i < 3; i++) begin
        m_im_q[i] <= mag(f_i_q[i]);
      end
    end
  end

  // Square stage.
  pl_t         s_pl_q;
  logic [63:0] s_c_q [3];
  logic [63:0] s_i_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_pl_q   <= m_pl_q;
      s_c_q[0] <= 64'(m_pl_q.cmx) * 64'(m_pl_q.cmx);
      s_c_q[1] <= 64'(m_pl_q.cmy) * 64'(m_pl_q.cmy);
      s_c_q[2] <= 64'(m_pl_q.cmz) * 64'(m_pl_q.cmz);
      for (int i = 0; i < 3; i++) begin
        s_i_q[i] <= 64'(m_im_q[i]) * 64'(m_im_q[i]);
      end
    end
  end

  // Sum stage feeds the square root pipelines.
  rt_t rc_q [SQRT_STEPS+1];
  rt_t ri_q [SQRT_STEPS+1];
  pl_t rp_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rc_q[0].x   <= s_c_q[0] + s_c_q[1] + s_c_q[2];
      rc_q[0].res <= '0;
      ri_q[0].x   <= s_i_q[0] + s_i_q[1] + s_i_q[2];
      ri_q[0].res <= '0;
      rp_q[0]     <= s_pl_q;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    localparam logic [63:0] SQB = 64'd1 << (2 * (SQRT_STEPS - 1 - g));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rc_q[g+1] <= sqrt_step(rc_q[g], SQB);
        ri_q[g+1] <= sqrt_step(ri_q[g], SQB);
        rp_q[g+1] <= rp_q[g];
      end
    end
  end

  // Length difference stage.
  pl_t         d_pl_q;
  logic [31:0] d_r_q, d_drm_q;
  logic        d_neg_q, d_nz_q, d_zero_q;
  logic [31:0] r_cur, r_ini;

  assign r_cur = rc_q[SQRT_STEPS].res[31:0];
  assign r_ini = ri_q[SQRT_STEPS].res[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_pl_q   <= rp_q[SQRT_STEPS];
      d_r_q    <= r_cur;
      d_drm_q  <= (r_cur > r_ini) ? (r_cur - r_ini) : (r_ini - r_cur);
      d_neg_q  <= r_cur > r_ini;
      d_nz_q   <= (r_cur != 32'd0) && (r_cur != r_ini);
      d_zero_q <= r_cur == 32'd0;
    end
  end

  // Product stage, then the divider pipeline with the energy alongside.
  dv_t dv_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].rem    <= 64'(d_pl_q.k) * 64'(d_drm_q);
      dv_q[0].d2     <= 64'(d_drm_q) * 64'(d_drm_q);
      dv_q[0].quo    <= '0;
      dv_q[0].r      <= d_r_q;
      dv_q[0].neg    <= d_neg_q;
      dv_q[0].nz     <= d_nz_q;
      dv_q[0].zero   <= d_zero_q;
      dv_q[0].hi     <= '0;
      dv_q[0].lo     <= '0;
      dv_q[0].energy <= '0;
      dv_q[0].pl     <= d_pl_q;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    localparam int DB = DIV_STEPS - 1 - g;
    dv_t         nx;
    logic [63:0] den;
    logic [63:0] esum;

    always_comb begin
      nx   = dv_q[g];
      den  = {32'd0, dv_q[g].r} << DB;
      esum = '0;
      if (dv_q[g].rem >= den) begin
        nx.rem     = dv_q[g].rem - den;
        nx.quo[DB] = 1'b1;
      end
      if (g == 0) begin
        nx.hi = 64'(dv_q[g].pl.k) * 64'(dv_q[g].d2[63:32]);
        nx.lo = 64'(dv_q[g].pl.k) * 64'(dv_q[g].d2[31:0]);
      end else if (g == 1) begin
        esum = (dv_q[g].hi << 16) + (dv_q[g].lo >> 16);
        if (!een_q) begin
          nx.energy = '0;
        end else if ((dv_q[g].hi >= (64'd1 << 47)) || esum[63]) begin
          nx.energy = '1;
        end else begin
          nx.energy = esum[62:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[g+1] <= nx;
      end
    end
  end

  // Scale stage.
  dv_t                dvo;
  logic               tb;
  logic [32:0]        mq;
  logic [31:0]        mneg, mpos;
  logic signed [31:0] sc_q;
  logic [31:0]        sm_q;
  logic               sn_q, sz_q;
  logic [62:0]        se_q;
  pl_t                sp_q;

  assign dvo  = dv_q[DIV_STEPS];
  assign tb   = {dvo.rem[32:0], 1'b0} >= {2'b00, dvo.r};
  assign mq   = dvo.quo[31] ? 33'h0_8000_0001 : ({1'b0, dvo.quo[30:0], 1'b0} + 33'(tb));
  assign mneg = (mq > 33'h0_8000_0000) ? 32'h8000_0000 : mq[31:0];
  assign mpos = (mq > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mq[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!dvo.nz) begin
        sc_q <= '0;
        sm_q <= '0;
      end else if (dvo.neg) begin
        sc_q <= ~mneg + 32'd1;
        sm_q <= mneg;
      end else begin
        sc_q <= mpos;
        sm_q <= mpos;
      end
      sn_q <= dvo.neg;
      sz_q <= dvo.zero;
      se_q <= dvo.energy;
      sp_q <= dvo.pl;
    end
  end

  // Force product stage.
  logic [63:0]        fp_q [3];
  logic               fn_q [3];
  logic signed [31:0] fs_q;
  logic               fz_q;
  logic [62:0]        fe_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fp_q[0] <= 64'(sp_q.cmx) * 64'(sm_q);
      fp_q[1] <= 64'(sp_q.cmy) * 64'(sm_q);
      fp_q[2] <= 64'(sp_q.cmz) * 64'(sm_q);
      fn_q[0] <= sp_q.csx ^ sn_q;
      fn_q[1] <= sp_q.csy ^ sn_q;
      fn_q[2] <= sp_q.csz ^ sn_q;
      fs_q    <= sc_q;
      fz_q    <= sz_q;
      fe_q    <= se_q;
    end
  end

  // Output register.
  hrbf_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.force_scale <= fs_q;
      out_q.force_x     <= sat_force(fp_q[0], fn_q[0]);
      out_q.force_y     <= sat_force(fp_q[1], fn_q[1]);
      out_q.force_z     <= sat_force(fp_q[2], fn_q[2]);
      out_q.bond_energy <= fe_q;
      out_q.zero_length <= fz_q;
    end
  end

  assign out_item_o = out_q;

  a_zero_len_no_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.zero_length |-> out_item_o.force_scale == 32'sd0)
    else $error("zero length item carries a nonzero force scale");

  a_zero_scale_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.force_scale == 32'sd0) |->
      (out_item_o.force_x == 32'sd0) && (out_item_o.force_y == 32'sd0) &&
      (out_item_o.force_z == 32'sd0))
    else $error("zero force scale gives a nonzero force");

  a_write_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.action == ACT_WRITE) |=> !v_q[0])
    else $error("stiffness write entered the pipeline as an item");

  a_bubble_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !v_q[NSTG-2] |=> !out_valid_o)
    else $error("output item appeared from an empty stage");

endmodule
